// ----- sv/bas_pkg.sv -----
// Shared types and constants for the bilinear ARGB sampler.
// Used by every module of the sampler; depends on nothing.
package bas_pkg;

   localparam int unsigned NEIGHBOURS = 4;
   localparam int unsigned CHANNELS   = 4;

   typedef logic [7:0]  chan_type;
   typedef logic [31:0] pixel_type;

   // Colour used for neighbours outside the source image
   localparam pixel_type FILL_ARGB = 32'h00FF_FFFF;

   // Configuration register indexes
   typedef enum logic [0:0] {
      REG_SRC_WIDTH  = 1'b0,
      REG_SRC_HEIGHT = 1'b1
   } reg_index_type;

   // Item after the bounds check and fill substitution
   typedef struct packed {
      chan_type                   fx;
      chan_type                   fy;
      pixel_type [NEIGHBOURS-1:0] pix;
   } fetch_type;

   // Item after the weight calculation
   typedef struct packed {
      chan_type  [NEIGHBOURS-1:0] weight;
      pixel_type [NEIGHBOURS-1:0] pix;
      logic                       all_white;
   } weight_type;

   // Channel c of a pixel: 0 alpha, 1 red, 2 green, 3 blue
   function automatic chan_type channel(input pixel_type p, input int unsigned c);
      chan_type ch;
      ch = p[(CHANNELS-1-c)*8 +: 8];
      return ch;
   endfunction

endpackage

// ----- sv/bilinear_argb_sampler_unit.sv -----
// Bilinear ARGB sampler: takes a signed 16.16 source coordinate with its 2x2 neighbour
// pixels and returns one interpolated ARGB pixel per item. Neighbours outside the
// configured source size read as the fill colour (A=0, R=G=B=255), and a neighbourhood
// that is white in R, G and B gives the fill colour. It accepts one item per clock
// while rsp does not stall it, and each item passes the pipeline registers in order:
// bounds check, weights, channel products, sum. Back-pressure on rsp stalls the
// stages behind a full register only; bubbles are squeezed out. Write src_width and
// src_height only while the pipeline is empty. Depends on bas_pkg, bas_fetch,
// bas_weight and bas_blend.
module bilinear_argb_sampler_unit (
   input  logic         clock,
   input  logic         reset,
   // configuration write channel
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [0:0]   csr_index,
   input  logic [15:0]  csr_data,
   // input items
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [191:0] req_tdata,   // x_fix, y_fix, pixel_tl, pixel_tr, pixel_bl, pixel_br
   // result items
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [31:0]  rsp_tdata    // alpha, red, green, blue
);
   import bas_pkg::*;

   logic [15:0]             width_ff;
   logic [15:0]             height_ff;
   pixel_type [3:0]         req_pix;
   logic                    s1_valid, s1_ready;
   fetch_type               s1_data;
   logic                    s2_valid, s2_ready;
   weight_type              s2_data;
   logic                    s3_valid;
   chan_type [3:0]          rsp_data;

   // Configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 16'd640;
         height_ff <= 16'd480;
      end else if (csr_valid && csr_ready) begin
         case (reg_index_type'(csr_index))
            REG_SRC_WIDTH: begin
               width_ff <= csr_data;
            end
            REG_SRC_HEIGHT: begin
               height_ff <= csr_data;
            end
            default: begin
            end
         endcase
      end
   end

   // Unpack the neighbour pixels: top-left, top-right, bottom-left, bottom-right
   always_comb begin
      for (int k = 0; k < NEIGHBOURS; k++) begin
         req_pix[k] = req_tdata[64 + 32*k +: 32];
      end
   end

   bas_fetch u_fetch (
      .clock      (clock),
      .reset      (reset),
      .src_width  (width_ff),
      .src_height (height_ff),
      .up_valid   (req_tvalid),
      .up_ready   (req_tready),
      .up_x       (req_tdata[31:0]),
      .up_y       (req_tdata[63:32]),
      .up_pix     (req_pix),
      .dn_valid   (s1_valid),
      .dn_ready   (s1_ready),
      .dn_data    (s1_data)
   );

   bas_weight u_weight (
      .clock    (clock),
      .reset    (reset),
      .up_valid (s1_valid),
      .up_ready (s1_ready),
      .up_data  (s1_data),
      .dn_valid (s2_valid),
      .dn_ready (s2_ready),
      .dn_data  (s2_data)
   );

   bas_blend u_blend (
      .clock     (clock),
      .reset     (reset),
      .up_valid  (s2_valid),
      .up_ready  (s2_ready),
      .up_data   (s2_data),
      .mid_valid (s3_valid),
      .dn_valid  (rsp_tvalid),
      .dn_ready  (rsp_tready),
      .dn_data   (rsp_data)
   );

   assign rsp_tdata = rsp_data;

`ifndef SYNTHESIS
   // A full pipeline held by the consumer takes no further item
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready && s1_valid && s2_valid && s3_valid) |-> !req_tready)
      else $error("item accepted into a full stalled pipeline");

   // A delivered result with nothing behind it leaves the output empty
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !s3_valid) |=> !rsp_tvalid)
      else $error("result repeated or invented");

   // Nothing comes out in the cycle after reset
   assert property (@(posedge clock)
      reset |=> (!rsp_tvalid && !s3_valid && !s2_valid && !s1_valid))
      else $error("pipeline not empty after reset");
`endif

endmodule

// ----- sv/bas_fetch.sv -----
// First pipeline stage: bounds check of the 2x2 neighbourhood and fill substitution.
// Depends on bas_pkg.
module bas_fetch (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [15:0]                         src_width,
   input  logic [15:0]                         src_height,
   input  logic                                up_valid,
   output logic                                up_ready,
   input  logic [31:0]                         up_x,
   input  logic [31:0]                         up_y,
   input  bas_pkg::pixel_type [3:0]            up_pix,
   output logic                                dn_valid,
   input  logic                                dn_ready,
   output bas_pkg::fetch_type                  dn_data
);
   import bas_pkg::*;

   logic              dn_valid_ff;
   fetch_type         data_ff;
   fetch_type         data_in;
   logic signed [17:0] px0, px1, py0, py1, wd, ht;
   logic [1:0]        out_x, out_y;

   // Integer positions and the bounds check for both columns and rows
   always_comb begin
      px0 = {{2{up_x[31]}}, up_x[31:16]};
      py0 = {{2{up_y[31]}}, up_y[31:16]};
      px1 = px0 + 18'sd1;
      py1 = py0 + 18'sd1;
      wd  = {2'b00, src_width};
      ht  = {2'b00, src_height};
      out_x[0] = (px0 < 18'sd0) || (px0 >= wd);
      out_x[1] = (px1 < 18'sd0) || (px1 >= wd);
      out_y[0] = (py0 < 18'sd0) || (py0 >= ht);
      out_y[1] = (py1 < 18'sd0) || (py1 >= ht);
   end

   // Substitute the fill colour for neighbours outside the image
   always_comb begin
      data_in.fx = up_x[15:8];
      data_in.fy = up_y[15:8];
      for (int k = 0; k < NEIGHBOURS; k++) begin
         data_in.pix[k] = (out_x[k % 2] || out_y[k / 2]) ? FILL_ARGB : up_pix[k];
      end
   end

   assign up_ready = !dn_valid_ff || dn_ready;

   // Advance when the next stage can take the item
   always_ff @(posedge clock) begin
      if (reset) begin
         dn_valid_ff <= 1'b0;
      end else if (up_ready) begin
         dn_valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = dn_valid_ff;
   assign dn_data  = data_ff;

endmodule

// ----- sv/bas_weight.sv -----
// Second pipeline stage: four bilinear weights from the 8-bit fractions.
// Depends on bas_pkg.
module bas_weight (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 up_valid,
   output logic                 up_ready,
   input  bas_pkg::fetch_type   up_data,
   output logic                 dn_valid,
   input  logic                 dn_ready,
   output bas_pkg::weight_type  dn_data
);
   import bas_pkg::*;

   logic        dn_valid_ff;
   weight_type  data_ff;
   weight_type  data_in;
   chan_type    ifx, ify;
   logic [15:0] prod [NEIGHBOURS];

   // Form the weights and flag an all-white neighbourhood
   always_comb begin
      ifx = ~up_data.fx;
      ify = ~up_data.fy;
      prod[0] = 16'(ifx) * 16'(ify);
      prod[1] = 16'(up_data.fx) * 16'(ify);
      prod[2] = 16'(ifx) * 16'(up_data.fy);
      prod[3] = 16'(up_data.fx) * 16'(up_data.fy);
      data_in.all_white = 1'b1;
      for (int k = 0; k < NEIGHBOURS; k++) begin
         data_in.weight[k] = prod[k][15:8];
         if (up_data.pix[k][23:0] != 24'hFF_FFFF) begin
            data_in.all_white = 1'b0;
         end
      end
      data_in.pix = up_data.pix;
   end

   assign up_ready = !dn_valid_ff || dn_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         dn_valid_ff <= 1'b0;
      end else if (up_ready) begin
         dn_valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = dn_valid_ff;
   assign dn_data  = data_ff;

endmodule

// ----- sv/bas_blend.sv -----
// Third and fourth pipeline stages: per-channel products, then sum and the white override.
// Depends on bas_pkg.
module bas_blend (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           up_valid,
   output logic                           up_ready,
   input  bas_pkg::weight_type            up_data,
   output logic                           mid_valid,
   output logic                           dn_valid,
   input  logic                           dn_ready,
   output bas_pkg::chan_type [3:0]        dn_data
);
   import bas_pkg::*;

   logic        prod_valid_ff;
   logic [15:0] prod_ff [CHANNELS][NEIGHBOURS];
   logic [15:0] prod_in [CHANNELS][NEIGHBOURS];
   logic        white_ff;
   logic        out_valid_ff;
   chan_type [CHANNELS-1:0] out_ff;
   chan_type [CHANNELS-1:0] out_in;
   logic [17:0] sum [CHANNELS];
   logic        out_load;

   // Multiply each channel of each neighbour by its weight
   always_comb begin
      for (int c = 0; c < CHANNELS; c++) begin
         for (int k = 0; k < NEIGHBOURS; k++) begin
            prod_in[c][k] = 16'(channel(up_data.pix[k], c)) * 16'(up_data.weight[k]);
         end
      end
   end

   assign out_load = !out_valid_ff || dn_ready;
   assign up_ready = !prod_valid_ff || out_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
      end else if (up_ready) begin
         prod_valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready) begin
         prod_ff  <= prod_in;
         white_ff <= up_data.all_white;
      end
   end

   // Sum the four products, drop the low byte, override an all-white neighbourhood
   always_comb begin
      for (int c = 0; c < CHANNELS; c++) begin
         sum[c] = 18'(prod_ff[c][0]) + 18'(prod_ff[c][1])
                + 18'(prod_ff[c][2]) + 18'(prod_ff[c][3]);
         out_in[c] = white_ff ? channel(FILL_ARGB, c) : sum[c][15:8];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= prod_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_ff <= out_in;
      end
   end

   assign mid_valid = prod_valid_ff;
   assign dn_valid  = out_valid_ff;
   assign dn_data   = out_ff;

endmodule
